// ----- design/rmq_pkg.sv -----
package rmq_pkg;

	// Field format
	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 14;

	// Internal widths
	localparam int ARG_W  = DATA_WIDTH + 3;          // trace / root argument
	localparam int NUM_W  = DATA_WIDTH + 1;          // off-diagonal sums and differences
	localparam int ROOT_W = DATA_WIDTH;              // integer square root result
	localparam int RAD_W  = 2 * ROOT_W;              // square root operand
	localparam int REM_W  = ROOT_W + 3;              // square root partial remainder
	localparam int DVD_W  = NUM_W + FRAC_BITS;       // dividend magnitude
	localparam int DVS_W  = ROOT_W + 1;              // divisor
	localparam int DREM_W = DVS_W + 1;               // divider partial remainder
	localparam int RAW_W  = DVD_W + 1;               // signed raw component

	// Pipeline depths: one root bit or one quotient bit per stage
	localparam int SQ_N = ROOT_W;
	localparam int DV_N = DVD_W;

	localparam logic signed [DATA_WIDTH-1:0] FMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] FMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [DATA_WIDTH-1:0] QONE = DATA_WIDTH'(1 << FRAC_BITS);
	localparam logic signed [ARG_W-1:0]      ARG_ONE = ARG_W'(1 << FRAC_BITS);

	// Component codes
	typedef logic [1:0] axis_t;
	localparam axis_t AX_X = 2'd0;
	localparam axis_t AX_Y = 2'd1;
	localparam axis_t AX_Z = 2'd2;
	localparam axis_t AX_W = 2'd3;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [DVD_W-1:0]  quo;
		logic [DREM_W-1:0] rem;
	} dv_t;

	typedef dv_t [3:0] dvq_t;
	typedef logic [3:0][DATA_WIDTH-1:0] quad_t;
	typedef logic [3:0][DVD_W-1:0] magq_t;

	typedef struct packed {
		logic       inv;
		axis_t      lead;
		logic [3:0] neg;
	} meta_t;

	// Cyclic successor of a diagonal axis
	function automatic axis_t next_axis(axis_t a);
		axis_t r;
		case (a)
			AX_X: r = AX_Y;
			AX_Y: r = AX_Z;
			default: r = AX_X;
		endcase
		return r;
	endfunction

	// One restoring step of the integer square root: two operand bits in, one root bit out
	function automatic sq_t sqrt_step(sq_t s);
		sq_t o;
		logic [REM_W-1:0] acc;
		logic [REM_W-1:0] trial;
		acc   = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
		trial = {1'b0, s.root, 2'b01};
		o.rad = s.rad << 2;
		if (acc >= trial) begin
			o.rem  = acc - trial;
			o.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = acc;
			o.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

	// One restoring step of unsigned division: one quotient bit out
	function automatic dv_t div_step(dv_t s, logic [DVS_W-1:0] d);
		dv_t o;
		logic [DREM_W-1:0] acc;
		logic ge;
		acc   = {s.rem[DREM_W-2:0], s.quo[DVD_W-1]};
		ge    = acc >= {1'b0, d};
		o.quo = {s.quo[DVD_W-2:0], ge};
		o.rem = ge ? acc - {1'b0, d} : acc;
		return o;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] clamp_field(logic signed [RAW_W-1:0] v);
		logic [DATA_WIDTH-1:0] r;
		if (v > RAW_W'(FMAX))
			r = FMAX;
		else if (v < RAW_W'(FMIN))
			r = FMIN;
		else
			r = v[DATA_WIDTH-1:0];
		return r;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] clamp_sym(logic signed [RAW_W-1:0] v);
		logic [DATA_WIDTH-1:0] r;
		if (v > RAW_W'(FMAX))
			r = FMAX;
		else if (v < -RAW_W'(FMAX))
			r = -FMAX;
		else
			r = v[DATA_WIDTH-1:0];
		return r;
	endfunction

endpackage

// ----- design/rmq_mat_if.sv -----
interface rmq_mat_if import rmq_pkg::*;;
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] m00, m01, m02;
	logic signed [DATA_WIDTH-1:0] m10, m11, m12;
	logic signed [DATA_WIDTH-1:0] m20, m21, m22;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

// ----- design/rmq_quat_if.sv -----
interface rmq_quat_if import rmq_pkg::*;;
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] quat_x, quat_y, quat_z, quat_w;
	logic invalid;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, invalid, input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, invalid, output ready);
endinterface

// ----- design/rotation_matrix_to_quaternion.sv -----
// Rotation matrix to quaternion converter.
// Channel mat (sink) carries one 3x3 rotation matrix per transaction, nine
// signed Q1.14 elements. Channel quat (source) returns x, y, z, w in signed
// Q1.14, saturated, and an invalid flag that marks an identity fallback.
// cfg_we / cfg_wdata write the normalise bit (1 = scale to unit length);
// write it only while no transaction is in flight.
// The pipeline holds 99 register stages. Throughput: one matrix per cycle
// while quat does not stall. The depth comes from two bit-serial square
// root pipelines of 16 stages each and two restoring divider pipelines of
// 31 stages each, plus five stages of setup, clamping, squaring, summing
// and output.
// Reset clears all valid bits and sets normalise to 1; the output register
// comes up empty.
// A stall on quat freezes every stage together; mat.ready follows
// !quat.valid || quat.ready, so a waiting result still lets a new matrix in
// as soon as the receiver takes it, and nothing is lost or repeated.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	rmq_mat_if.sink           mat,
	rmq_quat_if.source        quat
);

	logic adv;
	logic normalise_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			normalise_q <= 1'b1;
		else if (cfg_we)
			normalise_q <= cfg_wdata;
	end

	// Whole pipeline moves unless the output holds an untaken result
	logic v_s9;
	assign adv       = !v_s9 || quat.ready;
	assign mat.ready = adv;

	// ---------------- setup: trace, branch, root argument, numerators
	logic signed [DATA_WIDTH-1:0] mm [3][3];
	logic signed [ARG_W-1:0] tr, arg_e, arg;
	axis_t ii, jj, kk;
	logic pos;
	logic signed [NUM_W-1:0] nq [4];
	meta_t meta_c;
	magq_t mag_c;
	logic [NUM_W-1:0] amag;

	assign mm[0][0] = mat.m00;
	assign mm[0][1] = mat.m01;
	assign mm[0][2] = mat.m02;
	assign mm[1][0] = mat.m10;
	assign mm[1][1] = mat.m11;
	assign mm[1][2] = mat.m12;
	assign mm[2][0] = mat.m20;
	assign mm[2][1] = mat.m21;
	assign mm[2][2] = mat.m22;

	always_comb begin
		tr  = ARG_W'(mm[0][0]) + ARG_W'(mm[1][1]) + ARG_W'(mm[2][2]);
		pos = tr > 0;
		ii  = AX_X;
		if (mm[1][1] > mm[0][0])
			ii = AX_Y;
		if (mm[2][2] > mm[ii][ii])
			ii = AX_Z;
		jj    = next_axis(ii);
		kk    = next_axis(jj);
		arg_e = ARG_W'(mm[ii][ii]) - ARG_W'(mm[jj][jj]) - ARG_W'(mm[kk][kk]) + ARG_ONE;
		arg   = pos ? tr + ARG_ONE : arg_e;
		for (int c = 0; c < 4; c++)
			nq[c] = '0;
		if (pos) begin
			nq[AX_X] = NUM_W'(mm[2][1]) - NUM_W'(mm[1][2]);
			nq[AX_Y] = NUM_W'(mm[0][2]) - NUM_W'(mm[2][0]);
			nq[AX_Z] = NUM_W'(mm[1][0]) - NUM_W'(mm[0][1]);
		end else begin
			nq[AX_W] = NUM_W'(mm[kk][jj]) - NUM_W'(mm[jj][kk]);
			nq[jj]   = NUM_W'(mm[jj][ii]) + NUM_W'(mm[ii][jj]);
			nq[kk]   = NUM_W'(mm[kk][ii]) + NUM_W'(mm[ii][kk]);
		end
		meta_c.inv  = !pos && (arg_e <= 0);
		meta_c.lead = pos ? AX_W : ii;
		for (int c = 0; c < 4; c++) begin
			meta_c.neg[c] = nq[c][NUM_W-1];
			amag          = meta_c.neg[c] ? -nq[c] : nq[c];
			mag_c[c]      = {amag, {FRAC_BITS{1'b0}}};
		end
	end

	logic  v_s1;
	sq_t   st_s1;
	meta_t meta_s1;
	magq_t mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= mat.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1.rad  <= {arg[RAD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
			st_s1.rem  <= '0;
			st_s1.root <= '0;
			meta_s1    <= meta_c;
			mag_s1     <= mag_c;
		end
	end

	// ---------------- root of the argument, one bit per stage
	logic  v_s2    [SQ_N];
	sq_t   st_s2   [SQ_N];
	meta_t meta_s2 [SQ_N];
	magq_t mag_s2  [SQ_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < SQ_N; n++)
				v_s2[n] <= 1'b0;
		end else if (adv) begin
			v_s2[0] <= v_s1;
			for (int n = 1; n < SQ_N; n++)
				v_s2[n] <= v_s2[n-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s2[0]   <= sqrt_step(st_s1);
			meta_s2[0] <= meta_s1;
			mag_s2[0]  <= mag_s1;
			for (int n = 1; n < SQ_N; n++) begin
				st_s2[n]   <= sqrt_step(st_s2[n-1]);
				meta_s2[n] <= meta_s2[n-1];
				mag_s2[n]  <= mag_s2[n-1];
			end
		end
	end

	// ---------------- divide numerators by twice the root
	logic                    v_s3    [DV_N];
	dvq_t                    dv_s3   [DV_N];
	logic [DVS_W-1:0]        den_s3  [DV_N];
	logic [ROOT_W-2:0]       half_s3 [DV_N];
	meta_t                   meta_s3 [DV_N];
	dvq_t                    dv_in3;
	logic [DVS_W-1:0]        den_in3;

	always_comb begin
		den_in3 = {st_s2[SQ_N-1].root, 1'b0};
		for (int c = 0; c < 4; c++) begin
			dv_in3[c].quo = mag_s2[SQ_N-1][c];
			dv_in3[c].rem = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < DV_N; n++)
				v_s3[n] <= 1'b0;
		end else if (adv) begin
			v_s3[0] <= v_s2[SQ_N-1];
			for (int n = 1; n < DV_N; n++)
				v_s3[n] <= v_s3[n-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++)
				dv_s3[0][c] <= div_step(dv_in3[c], den_in3);
			den_s3[0]  <= den_in3;
			half_s3[0] <= st_s2[SQ_N-1].root[ROOT_W-1:1];
			meta_s3[0] <= meta_s2[SQ_N-1];
			for (int n = 1; n < DV_N; n++) begin
				for (int c = 0; c < 4; c++)
					dv_s3[n][c] <= div_step(dv_s3[n-1][c], den_s3[n-1]);
				den_s3[n]  <= den_s3[n-1];
				half_s3[n] <= half_s3[n-1];
				meta_s3[n] <= meta_s3[n-1];
			end
		end
	end

	// ---------------- signed raw components, clamp
	logic signed [RAW_W-1:0] raw4 [4];
	logic  v_s4;
	quad_t qcl_s4, qsat_s4;
	meta_t meta_s4;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			if (meta_s3[DV_N-1].lead == axis_t'(c))
				raw4[c] = RAW_W'(half_s3[DV_N-1]);
			else if (meta_s3[DV_N-1].neg[c])
				raw4[c] = -$signed({1'b0, dv_s3[DV_N-1][c].quo});
			else
				raw4[c] = $signed({1'b0, dv_s3[DV_N-1][c].quo});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (adv)
			v_s4 <= v_s3[DV_N-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				qcl_s4[c]  <= clamp_sym(raw4[c]);
				qsat_s4[c] <= clamp_field(raw4[c]);
			end
			meta_s4 <= meta_s3[DV_N-1];
		end
	end

	// ---------------- squares, then their sum
	logic v_s5, v_s6;
	logic [3:0][RAD_W-1:0] sqr_s5;
	logic [RAD_W-1:0] sum_s6;
	quad_t qcl_s5, qsat_s5, qcl_s6, qsat_s6;
	meta_t meta_s5, meta_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++)
				sqr_s5[c] <= RAD_W'($signed(qcl_s4[c])) * RAD_W'($signed(qcl_s4[c]));
			qcl_s5  <= qcl_s4;
			qsat_s5 <= qsat_s4;
			meta_s5 <= meta_s4;
			sum_s6  <= sqr_s5[0] + sqr_s5[1] + sqr_s5[2] + sqr_s5[3];
			qcl_s6  <= qcl_s5;
			qsat_s6 <= qsat_s5;
			meta_s6 <= meta_s5;
		end
	end

	// ---------------- root of the squared norm
	logic  v_s7    [SQ_N];
	sq_t   st_s7   [SQ_N];
	quad_t qcl_s7  [SQ_N];
	quad_t qsat_s7 [SQ_N];
	meta_t meta_s7 [SQ_N];
	sq_t   st_in7;

	always_comb begin
		st_in7.rad  = sum_s6;
		st_in7.rem  = '0;
		st_in7.root = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < SQ_N; n++)
				v_s7[n] <= 1'b0;
		end else if (adv) begin
			v_s7[0] <= v_s6;
			for (int n = 1; n < SQ_N; n++)
				v_s7[n] <= v_s7[n-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s7[0]   <= sqrt_step(st_in7);
			qcl_s7[0]  <= qcl_s6;
			qsat_s7[0] <= qsat_s6;
			meta_s7[0] <= meta_s6;
			for (int n = 1; n < SQ_N; n++) begin
				st_s7[n]   <= sqrt_step(st_s7[n-1]);
				qcl_s7[n]  <= qcl_s7[n-1];
				qsat_s7[n] <= qsat_s7[n-1];
				meta_s7[n] <= meta_s7[n-1];
			end
		end
	end

	// ---------------- divide clamped components by the norm
	logic             v_s8    [DV_N];
	dvq_t             dv_s8   [DV_N];
	logic [DVS_W-1:0] dvs_s8  [DV_N];
	logic             nz_s8   [DV_N];
	quad_t            qcl_s8  [DV_N];
	quad_t            qsat_s8 [DV_N];
	meta_t            meta_s8 [DV_N];
	dvq_t             dv_in8;
	logic [DVS_W-1:0] dvs_in8;
	logic [DATA_WIDTH-1:0] acl;

	always_comb begin
		dvs_in8 = {1'b0, st_s7[SQ_N-1].root};
		for (int c = 0; c < 4; c++) begin
			acl = qcl_s7[SQ_N-1][c][DATA_WIDTH-1] ? -qcl_s7[SQ_N-1][c] : qcl_s7[SQ_N-1][c];
			dv_in8[c].quo = DVD_W'(acl) << FRAC_BITS;
			dv_in8[c].rem = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < DV_N; n++)
				v_s8[n] <= 1'b0;
		end else if (adv) begin
			v_s8[0] <= v_s7[SQ_N-1];
			for (int n = 1; n < DV_N; n++)
				v_s8[n] <= v_s8[n-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++)
				dv_s8[0][c] <= div_step(dv_in8[c], dvs_in8);
			dvs_s8[0]  <= dvs_in8;
			nz_s8[0]   <= st_s7[SQ_N-1].root == '0;
			qcl_s8[0]  <= qcl_s7[SQ_N-1];
			qsat_s8[0] <= qsat_s7[SQ_N-1];
			meta_s8[0] <= meta_s7[SQ_N-1];
			for (int n = 1; n < DV_N; n++) begin
				for (int c = 0; c < 4; c++)
					dv_s8[n][c] <= div_step(dv_s8[n-1][c], dvs_s8[n-1]);
				dvs_s8[n]  <= dvs_s8[n-1];
				nz_s8[n]   <= nz_s8[n-1];
				qcl_s8[n]  <= qcl_s8[n-1];
				qsat_s8[n] <= qsat_s8[n-1];
				meta_s8[n] <= meta_s8[n-1];
			end
		end
	end

	// ---------------- pick the result, identity on failure
	logic inv9;
	quad_t q9;
	logic signed [RAW_W-1:0] nraw;
	quad_t q_s9;
	logic inv_s9;

	always_comb begin
		inv9 = meta_s8[DV_N-1].inv || (normalise_q && nz_s8[DV_N-1]);
		for (int c = 0; c < 4; c++) begin
			if (qcl_s8[DV_N-1][c][DATA_WIDTH-1])
				nraw = -$signed({1'b0, dv_s8[DV_N-1][c].quo});
			else
				nraw = $signed({1'b0, dv_s8[DV_N-1][c].quo});
			if (inv9)
				q9[c] = (axis_t'(c) == AX_W) ? QONE : '0;
			else if (normalise_q)
				q9[c] = clamp_field(nraw);
			else
				q9[c] = qsat_s8[DV_N-1][c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else if (adv)
			v_s9 <= v_s8[DV_N-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s9   <= q9;
			inv_s9 <= inv9;
		end
	end

	assign quat.valid   = v_s9;
	assign quat.quat_x  = q_s9[AX_X];
	assign quat.quat_y  = q_s9[AX_Y];
	assign quat.quat_z  = q_s9[AX_Z];
	assign quat.quat_w  = q_s9[AX_W];
	assign quat.invalid = inv_s9;

	// ---------------- checks
	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2[SQ_N-1] && !meta_s2[SQ_N-1].inv |-> st_s2[SQ_N-1].root != '0)
		else $error("root of a positive argument is zero");

	a_lead_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !meta_s4.inv |-> !qsat_s4[meta_s4.lead][DATA_WIDTH-1])
		else $error("leading component is negative");

	a_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8[DV_N-1] && nz_s8[DV_N-1] |-> qcl_s8[DV_N-1] == '0)
		else $error("zero norm with a nonzero component");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && quat.invalid |-> quat.quat_x == '0 && quat.quat_y == '0 &&
			quat.quat_z == '0 && quat.quat_w == QONE)
		else $error("invalid result is not the identity");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && !quat.invalid && normalise_q |->
			quat.quat_x <= QONE && quat.quat_x >= -QONE &&
			quat.quat_y <= QONE && quat.quat_y >= -QONE &&
			quat.quat_z <= QONE && quat.quat_z >= -QONE &&
			quat.quat_w <= QONE && quat.quat_w >= -QONE)
		else $error("normalised component exceeds one");

endmodule

// ----- tb/sv/rmq_checker.sv -----
`timescale 1ns / 100ps

module rmq_checker import rmq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	rmq_mat_if.sink   mat_mon,
	rmq_quat_if.sink  quat_mon,
	output int        fail_count,
	output int        pending_count
);

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] qx, qy, qz, qw;
		logic                         inv;
	} quat_item_t;

	quat_item_t quat_queue[$];
	logic       norm_on;

	// Integer square root of a 64-bit value, floor.
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Convert one matrix to the expected quaternion.
	function automatic quat_item_t matrix_to_quat(longint m[3][3], logic nrm);
		longint one, fmax, t, arg, den, n2, n;
		longint q[4];
		longint unsigned r;
		int i, j, k, a;
		logic bad;
		quat_item_t res;
		one = longint'(1) << FRAC_BITS;
		fmax = (longint'(1) << (DATA_WIDTH - 1)) - 1;
		bad = 1'b0;
		for (a = 0; a < 4; a++)
			q[a] = 0;
		t = m[0][0] + m[1][1] + m[2][2];
		if (t > 0) begin
			arg = t + one;
			r = int_sqrt(longint'(arg) << FRAC_BITS);
			den = 2 * longint'(r);
			q[3] = longint'(r >> 1);
			q[0] = (m[2][1] - m[1][2]) * one / den;
			q[1] = (m[0][2] - m[2][0]) * one / den;
			q[2] = (m[1][0] - m[0][1]) * one / den;
		end else begin
			i = 0;
			if (m[1][1] > m[0][0])
				i = 1;
			if (m[2][2] > m[i][i])
				i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			arg = m[i][i] - m[j][j] - m[k][k] + one;
			if (arg <= 0) begin
				bad = 1'b1;
			end else begin
				r = int_sqrt(longint'(arg) << FRAC_BITS);
				den = 2 * longint'(r);
				q[i] = longint'(r >> 1);
				q[3] = (m[k][j] - m[j][k]) * one / den;
				q[j] = (m[j][i] + m[i][j]) * one / den;
				q[k] = (m[k][i] + m[i][k]) * one / den;
			end
		end
		if (!bad && nrm) begin
			n2 = 0;
			for (a = 0; a < 4; a++) begin
				q[a] = sat(q[a], -fmax, fmax);
				n2 += q[a] * q[a];
			end
			n = longint'(int_sqrt(n2));
			if (n == 0)
				bad = 1'b1;
			else
				for (a = 0; a < 4; a++)
					q[a] = q[a] * one / n;
		end
		if (bad) begin
			q[0] = 0;
			q[1] = 0;
			q[2] = 0;
			q[3] = one;
		end
		res.qx = DATA_WIDTH'(sat(q[0], -fmax - 1, fmax));
		res.qy = DATA_WIDTH'(sat(q[1], -fmax - 1, fmax));
		res.qz = DATA_WIDTH'(sat(q[2], -fmax - 1, fmax));
		res.qw = DATA_WIDTH'(sat(q[3], -fmax - 1, fmax));
		res.inv = bad;
		return res;
	endfunction

	assign pending_count = quat_queue.size();

	// Track the register, predict on accepted matrices, compare on accepted results.
	always @(posedge clk or negedge arst_n) begin
		longint m[3][3];
		quat_item_t exp_q;
		if (!arst_n) begin
			norm_on <= 1'b1;
			fail_count <= 0;
			quat_queue.delete();
		end else begin
			if (cfg_we)
				norm_on <= cfg_wdata;
			if (mat_mon.valid && mat_mon.ready) begin
				m[0][0] = mat_mon.m00; m[0][1] = mat_mon.m01; m[0][2] = mat_mon.m02;
				m[1][0] = mat_mon.m10; m[1][1] = mat_mon.m11; m[1][2] = mat_mon.m12;
				m[2][0] = mat_mon.m20; m[2][1] = mat_mon.m21; m[2][2] = mat_mon.m22;
				quat_queue.push_back(matrix_to_quat(m, norm_on));
			end
			if (quat_mon.valid && quat_mon.ready) begin
				if (quat_queue.size() == 0) begin
					$error("quaternion transaction with none expected");
					fail_count <= fail_count + 1;
				end else begin
					exp_q = quat_queue.pop_front();
					if (exp_q.qx !== quat_mon.quat_x ||
					    exp_q.qy !== quat_mon.quat_y ||
					    exp_q.qz !== quat_mon.quat_z ||
					    exp_q.qw !== quat_mon.quat_w ||
					    exp_q.inv !== quat_mon.invalid)
						fail_count <= fail_count + 1;
					if (exp_q.qx !== quat_mon.quat_x)
						$error("quat_x expected %0d got %0d", exp_q.qx, quat_mon.quat_x);
					if (exp_q.qy !== quat_mon.quat_y)
						$error("quat_y expected %0d got %0d", exp_q.qy, quat_mon.quat_y);
					if (exp_q.qz !== quat_mon.quat_z)
						$error("quat_z expected %0d got %0d", exp_q.qz, quat_mon.quat_z);
					if (exp_q.qw !== quat_mon.quat_w)
						$error("quat_w expected %0d got %0d", exp_q.qw, quat_mon.quat_w);
					if (exp_q.inv !== quat_mon.invalid)
						$error("invalid expected %0b got %0b", exp_q.inv, quat_mon.invalid);
				end
			end
		end
	end

endmodule

// ----- tb/sv/rotation_matrix_to_quaternion_tb.sv -----
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_tb;
	import rmq_pkg::*;

	localparam int CFG_NORMALISE = 0;
	localparam int STALL_LIMIT   = 20000;
	localparam int DRAIN_CYCLES  = 120;
	localparam int RANDOM_ITEMS  = 1600;

	typedef logic signed [DATA_WIDTH-1:0] elem_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   fail_count;
	int   pending_count;
	int   idle_cycles;
	int   sent_count;
	int   norm_writes;
	bit   timed_out;

	rmq_mat_if  mat_ch ();
	rmq_quat_if quat_ch ();

	rotation_matrix_to_quaternion dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mat       (mat_ch.sink),
		.quat      (quat_ch.source)
	);

	rmq_checker quat_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mat_mon       (mat_ch.sink),
		.quat_mon      (quat_ch.sink),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Receiver: stall at random, with stretches of no stall.
	initial begin
		int g;
		quat_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 3) == 0) begin
				quat_ch.ready <= 1'b1;
				repeat ($urandom_range(50, 200)) @(posedge clk);
			end else begin
				g = gap_len();
				if (g > 0) begin
					quat_ch.ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
				quat_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Watchdog: count cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((mat_ch.valid && mat_ch.ready) || (quat_ch.valid && quat_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Drive one matrix and hold until accepted.
	task automatic send_matrix(elem_t e[9], bit allow_gap);
		int g;
		g = allow_gap ? gap_len() : 0;
		if (g > 0) begin
			mat_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		mat_ch.valid <= 1'b1;
		mat_ch.m00 <= e[0]; mat_ch.m01 <= e[1]; mat_ch.m02 <= e[2];
		mat_ch.m10 <= e[3]; mat_ch.m11 <= e[4]; mat_ch.m12 <= e[5];
		mat_ch.m20 <= e[6]; mat_ch.m21 <= e[7]; mat_ch.m22 <= e[8];
		@(posedge clk);
		while (!mat_ch.ready)
			@(posedge clk);
		sent_count++;
	endtask

	// Drop valid and wait until every expected result is back.
	task automatic drain();
		mat_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_norm(logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		norm_writes++;
	endtask

	// Rotation-like matrix with a random dominant diagonal and small off-diagonals.
	function automatic void rot_like(output elem_t e[9]);
		int lead, s;
		for (int a = 0; a < 9; a++)
			e[a] = elem_t'($signed($urandom_range(0, 16384)) - 8192);
		lead = $urandom_range(0, 3);
		s = $urandom_range(0, 1) ? 16384 : -16384;
		if (lead < 3) begin
			for (int a = 0; a < 3; a++)
				e[a * 4] = elem_t'(a == lead ? 16384 - $urandom_range(0, 3000)
				                              : -16384 + $urandom_range(0, 6000));
		end else begin
			for (int a = 0; a < 3; a++)
				e[a * 4] = elem_t'(s - (s > 0 ? 1 : -1) * $urandom_range(0, 9000));
		end
	endfunction

	function automatic void directed(int n, output elem_t e[9]);
		elem_t ex, mn;
		ex = elem_t'(32767);
		mn = elem_t'(-32768);
		for (int a = 0; a < 9; a++)
			e[a] = '0;
		case (n)
			0: begin e[0] = 16384; e[4] = 16384; e[8] = 16384; end
			1: begin e[0] = 16384; e[4] = -16384; e[8] = -16384; end
			2: begin e[0] = -16384; e[4] = 16384; e[8] = -16384; end
			3: begin e[0] = -16384; e[4] = -16384; e[8] = 16384; end
			4: ;
			5: begin e[0] = -16384; e[4] = -16384; e[8] = -16384; end
			6: for (int a = 0; a < 9; a++) e[a] = ex;
			7: for (int a = 0; a < 9; a++) e[a] = mn;
			8: begin e[0] = 1; e[1] = mn; e[3] = ex; e[2] = ex; e[6] = mn; end
			9: begin e[0] = mn; e[4] = mn; e[8] = mn; e[1] = ex; e[3] = ex; end
			10: begin e[0] = ex; e[4] = mn; e[8] = mn; e[1] = ex; e[3] = ex;
				e[2] = ex; e[6] = ex; end
			11: begin e[0] = -16384; e[4] = 16384; e[8] = 16384; end
			12: begin e[0] = 5; e[4] = 5; e[8] = 5; end
			13: begin e[0] = -30000; e[4] = -30000; e[8] = -30000; e[7] = ex;
				e[5] = mn; end
			default: for (int a = 0; a < 9; a++) e[a] = elem_t'($urandom);
		endcase
	endfunction

	initial begin
		elem_t e[9];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		mat_ch.valid = 1'b0;
		mat_ch.m00 = '0; mat_ch.m01 = '0; mat_ch.m02 = '0;
		mat_ch.m10 = '0; mat_ch.m11 = '0; mat_ch.m12 = '0;
		mat_ch.m20 = '0; mat_ch.m21 = '0; mat_ch.m22 = '0;
		idle_cycles = 0;
		sent_count = 0;
		norm_writes = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under both register settings, starting from reset value.
		for (int ph = 0; ph < 3; ph++) begin
			if (ph > 0)
				write_norm(ph == 1 ? 1'b0 : 1'b1);
			for (int n = 0; n < 16; n++) begin
				directed(n, e);
				send_matrix(e, 1'b0);
			end
			drain();
		end

		// Random phases alternating the register setting.
		for (int ph = 0; ph < 8; ph++) begin
			write_norm(ph[0]);
			for (int n = 0; n < RANDOM_ITEMS / 8; n++) begin
				if ($urandom_range(0, 9) < 7)
					rot_like(e);
				else
					for (int a = 0; a < 9; a++)
						e[a] = elem_t'($urandom);
				send_matrix(e, ph % 3 != 2);
			end
			drain();
		end

		$display("Sent %0d matrices across trace and each diagonal branch,", sent_count);
		$display("invalid and saturating cases, %0d normalise writes.", norm_writes);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/rmq_pkg.sv
design/rmq_mat_if.sv
design/rmq_quat_if.sv
design/rotation_matrix_to_quaternion.sv
tb/sv/rmq_checker.sv
tb/sv/rotation_matrix_to_quaternion_tb.sv
